[hdl/pif_pkg.sv]
package pif_pkg;

   // table geometry
   localparam int PROBE_COUNT     = 8;
   localparam int SLOTS_PER_PROBE = 8;
   localparam int SLOT_TOTAL      = PROBE_COUNT * SLOTS_PER_PROBE;
   localparam int PROBE_W = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;
   localparam int SLOT_W  = (SLOTS_PER_PROBE > 1) ? $clog2(SLOTS_PER_PROBE) : 1;
   localparam int SLOT_AW = (SLOT_TOTAL > 1) ? $clog2(SLOT_TOTAL) : 1;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // highest bit index for a bit flip
   localparam int BIT_INDEX_MAX = 31;

   // operations
   localparam logic [1:0] OP_INJECT    = 2'd0;
   localparam logic [1:0] OP_ADD       = 2'd1;
   localparam logic [1:0] OP_CLEAR     = 2'd2;
   localparam logic [1:0] OP_RESET_CNT = 2'd3;

   // fault kinds
   localparam logic [2:0] FK_NONE   = 3'd0;
   localparam logic [2:0] FK_FLIP   = 3'd1;
   localparam logic [2:0] FK_OFFSET = 3'd2;
   localparam logic [2:0] FK_GAIN   = 3'd3;
   localparam logic [2:0] FK_SET    = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SLOT  = 2'd1;
   localparam logic [1:0] ST_NO_PROBE = 2'd2;

   // one fault step handed to the arithmetic unit
   typedef struct packed {
      logic              act;
      logic [2:0]        kind;
      logic signed [31:0] param;
   } fault_op_type;

   // one entry of the slot memory
   typedef struct packed {
      logic [2:0]        kind;
      logic signed [31:0] param;
      logic [31:0]       start;
      logic [30:0]       length;
   } slot_entry_type;

endpackage

[hdl/pif_if.sv]
interface pif_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [15:0]        probe_key;
   logic signed [31:0] data_value;
   logic [2:0]         fault_kind;
   logic signed [31:0] fault_param;
   logic [30:0]        start_delay;
   logic [30:0]        fault_length;

   modport source (output valid, operation, probe_key, data_value, fault_kind,
                   fault_param, start_delay, fault_length, input ready);
   modport sink (input valid, operation, probe_key, data_value, fault_kind,
                 fault_param, start_delay, fault_length, output ready);
endinterface

interface pif_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value_out;
   logic [1:0]         status;

   modport source (output valid, value_out, status, input ready);
   modport sink (input valid, value_out, status, output ready);
endinterface

[hdl/pif_fault_unit.sv]
module pif_fault_unit (
   input  logic                 clock,
   input  logic                 load,
   input  pif_pkg::fault_op_type op,
   input  logic signed [31:0]   value_in,
   output logic signed [31:0]   value_out
);
   import pif_pkg::*;

   logic               act_ff;
   logic [2:0]         kind_ff;
   logic signed [31:0] param_ff;
   logic signed [31:0] value_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic signed [47:0] quot;
   logic signed [31:0] sat_val;
   logic signed [31:0] set_val;
   logic [4:0]         flip_idx;

   // first half: product for gain, scaled sum for offset
   always_comb begin
      if (op.kind == FK_GAIN) begin
         prod_in = 64'(value_in) * 64'(op.param);
      end else begin
         prod_in = (64'(value_in) <<< 16) + 64'(op.param);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         act_ff   <= op.act;
         kind_ff  <= op.kind;
         param_ff <= op.param;
         value_ff <= value_in;
         prod_ff  <= prod_in;
      end
   end

   // divide by 2^16 toward zero, then saturate to 32 bits
   always_comb begin
      quot = prod_ff[63:16];
      if (prod_ff[63] && (prod_ff[15:0] != 16'd0)) begin
         quot = quot + 48'sd1;
      end
      if ((quot[47:31] != 17'd0) && (quot[47:31] != '1)) begin
         sat_val = quot[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat_val = quot[31:0];
      end
   end

   // set-to value and clamped flip index
   always_comb begin
      set_val = {{16{param_ff[31]}}, param_ff[31:16]};
      if (param_ff[31] && (param_ff[15:0] != 16'd0)) begin
         set_val = set_val + 32'sd1;
      end
      if (param_ff[31]) begin
         flip_idx = 5'd0;
      end else if (param_ff[30:21] != 10'd0) begin
         flip_idx = 5'(BIT_INDEX_MAX);
      end else begin
         flip_idx = param_ff[20:16];
      end
   end

   always_comb begin
      value_out = value_ff;
      if (act_ff) begin
         case (kind_ff)
            FK_FLIP: begin
               value_out = value_ff ^ (32'd1 << flip_idx);
            end
            FK_OFFSET, FK_GAIN: begin
               value_out = sat_val;
            end
            FK_SET: begin
               value_out = set_val;
            end
            default: begin
               value_out = value_ff;
            end
         endcase
      end
   end

endmodule

[hdl/probe_fault_injector.sv]
// Channel   Direction  Contents
// req_chan  in         operation, probe_key, data_value, fault_kind, fault_param,
//                      start_delay, fault_length
// rsp_chan  out        value_out, status
// apb       in/out     inject_enable at byte address 0
//
// Add, clear and counter reset pass through EXEC and then DONE.
// An inject walks each matching probe's slots through the slot memory:
// each slot passes through EX and WB (memory read, shared multiplier);
// an unmatched inject goes from SEL to DONE, a disabled one from EXEC to DONE.
// Reset is synchronous; slot contents need no clearing, slot valid bits reset.
// A result waits in the output register while the next item is taken.
module probe_fault_injector (
   input  logic                         clock,
   input  logic                         reset,
   pif_req_if.sink                      req_chan,
   pif_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pif_pkg::CSR_AW-1:0]   paddr,
   input  logic [pif_pkg::CSR_DW-1:0]   pwdata,
   output logic [pif_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready
);
   import pif_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_SEL, S_EX, S_WB, S_DONE
   } state_type;

   state_type             state_ff;
   logic                  enable_ff;
   logic [1:0]            op_ff;
   logic [15:0]           key_ff;
   logic signed [31:0]    value_ff;
   logic [2:0]            kind_ff;
   logic signed [31:0]    param_ff;
   logic [30:0]           delay_ff;
   logic [30:0]           length_ff;
   logic [1:0]            status_ff;
   logic [PROBE_COUNT-1:0] match_ff;
   logic [PROBE_W-1:0]    probe_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [30:0]           iter_snap_ff;
   logic                  rsp_valid_ff;
   logic signed [31:0]    rsp_value_ff;
   logic [1:0]            rsp_status_ff;

   logic [15:0]           probe_key_ff   [PROBE_COUNT];
   logic [PROBE_COUNT-1:0] probe_used_ff;
   logic [30:0]           probe_iter_ff  [PROBE_COUNT];
   logic [SLOT_TOTAL-1:0] slot_used_ff;

   slot_entry_type        slot_mem [SLOT_TOTAL];
   slot_entry_type        rd_data_ff;
   logic                  rd_en;
   logic [SLOT_AW-1:0]    rd_addr;
   logic                  wr_en;
   logic [SLOT_AW-1:0]    wr_addr;
   slot_entry_type        wr_data;

   logic                  req_xfer;
   logic                  csr_write;

   // add lookup
   logic                  add_found;
   logic [PROBE_W-1:0]    add_probe;
   logic                  add_is_new;
   logic                  slot_found;
   logic [SLOT_W-1:0]     slot_free;

   // inject walk
   logic [PROBE_COUNT-1:0] match_now;
   logic [PROBE_W-1:0]    pick;
   logic [SLOT_AW-1:0]    cur_base;
   logic [31:0]           iter_ext;
   logic [31:0]           iter_diff;
   logic                  win_act;
   fault_op_type          fop;
   logic signed [31:0]    unit_out;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[CSR_AW-1] == 1'b0);
   assign prdata    = (paddr[CSR_AW-1] == 1'b0) ? CSR_DW'(enable_ff) : '0;

   assign req_chan.ready   = (state_ff == S_IDLE);
   assign req_xfer         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.value_out = rsp_value_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // probes addressed by an inject
   always_comb begin
      for (int i = 0; i < PROBE_COUNT; i++) begin
         match_now[i] = probe_used_ff[i] && (probe_key_ff[i] == key_ff);
      end
   end

   // lowest pending match
   always_comb begin
      pick = '0;
      for (int i = PROBE_COUNT - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            pick = PROBE_W'(i);
         end
      end
   end

   // add: same key first, else first inactive probe, then first free slot
   always_comb begin
      add_found  = 1'b0;
      add_probe  = '0;
      add_is_new = 1'b0;
      for (int i = 0; i < PROBE_COUNT; i++) begin
         if (!add_found && (probe_key_ff[i] == key_ff)) begin
            add_found = 1'b1;
            add_probe = PROBE_W'(i);
         end
      end
      for (int i = 0; i < PROBE_COUNT; i++) begin
         if (!add_found && !probe_used_ff[i]) begin
            add_found  = 1'b1;
            add_is_new = 1'b1;
            add_probe  = PROBE_W'(i);
         end
      end
      slot_found = 1'b0;
      slot_free  = '0;
      for (int j = 0; j < SLOTS_PER_PROBE; j++) begin
         if (!slot_found &&
             !slot_used_ff[SLOT_AW'(add_probe) * SLOT_AW'(SLOTS_PER_PROBE) + SLOT_AW'(j)]) begin
            slot_found = 1'b1;
            slot_free  = SLOT_W'(j);
         end
      end
   end

   assign wr_addr = SLOT_AW'(add_probe) * SLOT_AW'(SLOTS_PER_PROBE) + SLOT_AW'(slot_free);
   assign wr_data = '{kind: kind_ff, param: param_ff,
                      start: {1'b0, delay_ff} + {1'b0, probe_iter_ff[add_probe]},
                      length: length_ff};
   assign wr_en   = (state_ff == S_EXEC) && (op_ff == OP_ADD) && add_found && slot_found;

   // slot memory reads: first slot on probe select, next slot during EX
   assign cur_base = SLOT_AW'(probe_ff) * SLOT_AW'(SLOTS_PER_PROBE);
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if ((state_ff == S_SEL) && (match_ff != '0)) begin
         rd_en   = 1'b1;
         rd_addr = SLOT_AW'(pick) * SLOT_AW'(SLOTS_PER_PROBE);
      end else if ((state_ff == S_EX) && (slot_ff != SLOT_W'(SLOTS_PER_PROBE - 1))) begin
         rd_en   = 1'b1;
         rd_addr = cur_base + SLOT_AW'(slot_ff) + SLOT_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // fault window of the slot under evaluation
   assign iter_ext  = {1'b0, iter_snap_ff};
   assign iter_diff = iter_ext - rd_data_ff.start;
   always_comb begin
      win_act = slot_used_ff[cur_base + SLOT_AW'(slot_ff)] && (iter_ext >= rd_data_ff.start);
      if ((rd_data_ff.length != 31'd0) && ({1'b0, rd_data_ff.length} <= iter_diff)) begin
         win_act = 1'b0;
      end
   end
   assign fop = '{act: win_act, kind: rd_data_ff.kind, param: rd_data_ff.param};

   pif_fault_unit u_fault (
      .clock     (clock),
      .load      (state_ff == S_EX),
      .op        (fop),
      .value_in  (value_ff),
      .value_out (unit_out)
   );

   // sequencer, table state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         enable_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         probe_used_ff <= '0;
         slot_used_ff  <= '0;
         match_ff      <= '0;
         for (int i = 0; i < PROBE_COUNT; i++) begin
            probe_key_ff[i]  <= '0;
            probe_iter_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            enable_ff <= pwdata[0];
         end
         // a new result in DONE takes over from the one leaving
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  op_ff     <= req_chan.operation;
                  key_ff    <= req_chan.probe_key;
                  value_ff  <= req_chan.data_value;
                  kind_ff   <= req_chan.fault_kind;
                  param_ff  <= req_chan.fault_param;
                  delay_ff  <= req_chan.start_delay;
                  length_ff <= req_chan.fault_length;
                  status_ff <= ST_OK;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= ((op_ff == OP_INJECT) && enable_ff) ? S_SEL : S_DONE;
               case (op_ff)
                  OP_INJECT: begin
                     if (enable_ff) begin
                        match_ff <= match_now;
                     end
                  end
                  OP_ADD: begin
                     if (!add_found) begin
                        status_ff <= ST_NO_PROBE;
                     end else begin
                        probe_used_ff[add_probe] <= 1'b1;
                        if (add_is_new) begin
                           probe_key_ff[add_probe] <= key_ff;
                        end
                        if (slot_found) begin
                           slot_used_ff[wr_addr] <= 1'b1;
                        end else begin
                           status_ff <= ST_NO_SLOT;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     probe_used_ff <= '0;
                     slot_used_ff  <= '0;
                     for (int i = 0; i < PROBE_COUNT; i++) begin
                        probe_iter_ff[i] <= '0;
                     end
                  end
                  default: begin
                     for (int i = 0; i < PROBE_COUNT; i++) begin
                        probe_iter_ff[i] <= '0;
                     end
                  end
               endcase
            end
            S_SEL: begin
               if (match_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  match_ff[pick] <= 1'b0;
                  probe_ff       <= pick;
                  iter_snap_ff   <= probe_iter_ff[pick];
                  slot_ff        <= '0;
                  state_ff       <= S_EX;
               end
            end
            S_EX: begin
               state_ff <= S_WB;
            end
            S_WB: begin
               value_ff <= unit_out;
               if (slot_ff == SLOT_W'(SLOTS_PER_PROBE - 1)) begin
                  if (iter_snap_ff != '1) begin
                     probe_iter_ff[probe_ff] <= iter_snap_ff + 31'd1;
                  end
                  state_ff <= S_SEL;
               end else begin
                  slot_ff  <= slot_ff + SLOT_W'(1);
                  state_ff <= S_EX;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_value_ff  <= value_ff;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[hdl/pif_checker.sv]
module pif_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [1:0]  rsp_status,
   input logic        pready
);

   // a result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   // nothing is offered right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a result never shows straight after the transfer of its request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared without processing time");

   // status is only ever one of the three defined codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("undefined status code");

   // configuration never waits
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready deasserted");

endmodule

bind probe_fault_injector pif_checker u_pif_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value_out),
   .rsp_status (rsp_chan.status),
   .pready     (pready)
);
